[rtl/rti_pkg.sv]
`default_nettype none

package rti_pkg;

  // pipeline shape: stage 1 captures the word, stage NSTG is the output register
  localparam int unsigned NSTG     = 41;
  localparam int unsigned DIV_N    = 31;  // quotient bits of the t divide (S7..S37)
  localparam int unsigned TOL_N    = 36;  // sqrt, scale and divide by ten (S5..S40)
  localparam int unsigned CTL_N    = 35;  // control carried from S6 to S40
  localparam int unsigned NUM_VERT = 3;

  localparam logic        REG_IDX_EPS = 1'b0;
  localparam logic [16:0] EPS_RESET   = 17'd3;
  localparam logic [16:0] Q_ONE       = 17'd65536;
  localparam logic [30:0] T_MAX       = 31'h7FFF_FFFF;

  typedef struct packed {
    logic        miss;
    logic        tneg;
    logic        tovf;
    logic        dabs_big;
    logic [29:0] dabs_lo;
    logic [31:0] time_tag;
  } rti_ctl_t;

  // a - b saturated to 32-bit signed
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return d[31:0];
  endfunction

  // Q16.16 product, floored
  function automatic logic signed [47:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

  function automatic logic [62:0] square(input logic signed [31:0] a);
    logic signed [63:0] p;
    p = a * a;
    return p[62:0];
  endfunction

  // a - b of two products, saturated to 32-bit signed
  function automatic logic signed [31:0] cross_sat(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic signed [48:0] d;
    d = $signed({a[47], a}) - $signed({b[47], b});
    if (d > 49'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (d < -49'sd2147483648) begin
      return 32'h8000_0000;
    end
    return d[31:0];
  endfunction

  function automatic logic signed [49:0] sum3(input logic signed [47:0] a,
                                              input logic signed [47:0] b,
                                              input logic signed [47:0] c);
    return $signed({{2{a[47]}}, a}) + $signed({{2{b[47]}}, b})
         + $signed({{2{c[47]}}, c});
  endfunction

  // one long-division-by-ten step on a hex digit: returns {quotient nibble, remainder}
  function automatic logic [7:0] div10_step(input logic [3:0] r, input logic [3:0] nib);
    logic [7:0]  v;
    logic [15:0] p;
    logic [3:0]  q;
    logic [7:0]  rr;
    v  = {r, nib};
    p  = {8'd0, v} * 16'd205;
    q  = p[14:11];
    rr = v - {4'd0, q} * 8'd10;
    return {q, rr[3:0]};
  endfunction

endpackage

`default_nettype wire

[rtl/rti_if.sv]
`default_nettype none

// ray / vertex words into the block
interface rti_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [1:0]         vertex_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic [31:0]        ray_time;

  modport source (output valid, action, vertex_index, pos_x, pos_y, pos_z,
                  dir_x, dir_y, dir_z, ray_time, input ready);
  modport sink   (input valid, action, vertex_index, pos_x, pos_y, pos_z,
                  dir_x, dir_y, dir_z, ray_time, output ready);
endinterface

// hit words out of the block
interface rti_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] distance;
  logic [16:0]        bary_first;
  logic [16:0]        bary_second;
  logic [16:0]        bary_third;
  logic [31:0]        hit_time;

  modport source (output valid, hit, distance, bary_first, bary_second, bary_third,
                  hit_time, input ready);
  modport sink   (input valid, hit, distance, bary_first, bary_second, bary_third,
                  hit_time, output ready);
endinterface

`default_nettype wire

[rtl/ray_triangle_intersect.sv]
// Ray / triangle hit test, Q16.16 fixed point, 41-stage pipeline.
// Throughput: one ray per cycle unless out_ch.ready stalls a full pipeline; the length
// of the t divider (31 stages) and the tolerance square root (32 stages) set the depth.
// Reset clears the pipeline valid bits and sets epsilon_scale to 3;
// vertices hold no reset value until written.
`default_nettype none

module ray_triangle_intersect (
  input  logic        clk_i,
  input  logic        rst_ni,
  rti_in_if.sink      in_ch,
  rti_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rti_pkg::*;

  // ---------------- configuration ----------------
  logic [16:0] eps_scale_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_EPS) ? {15'd0, eps_scale_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_scale_q <= EPS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_IDX_EPS) begin
      eps_scale_q <= pwdata[16:0];
    end
  end

  // ---------------- stage enables (bubbles collapse) ----------------
  logic [NSTG:1] v_q;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !v_q[NSTG] || out_ch.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_ch.valid && in_ch.action;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------- vertex store ----------------
  logic signed [31:0] vtx_q [9];
  logic               load_acc;

  assign load_acc = in_ch.valid && en[1] && !in_ch.action;

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < NUM_VERT; w++) begin
      if (load_acc && in_ch.vertex_index == 2'(w)) begin
        vtx_q[3*w]   <= in_ch.pos_x;
        vtx_q[3*w+1] <= in_ch.pos_y;
        vtx_q[3*w+2] <= in_ch.pos_z;
      end
    end
  end

  // ---------------- S1: edges, origin offset ----------------
  logic signed [31:0] pos_c [3];
  logic signed [31:0] dir_c [3];
  logic signed [31:0] e1_s1_q [3], e2_s1_q [3], tv_s1_q [3], dir_s1_q [3];
  logic [31:0]        tm_q [5];

  assign pos_c[0] = in_ch.pos_x;
  assign pos_c[1] = in_ch.pos_y;
  assign pos_c[2] = in_ch.pos_z;
  assign dir_c[0] = in_ch.dir_x;
  assign dir_c[1] = in_ch.dir_y;
  assign dir_c[2] = in_ch.dir_z;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int c = 0; c < 3; c++) begin
        e1_s1_q[c]  <= sat_sub(vtx_q[3+c], vtx_q[c]);
        e2_s1_q[c]  <= sat_sub(vtx_q[6+c], vtx_q[c]);
        tv_s1_q[c]  <= sat_sub(pos_c[c], vtx_q[c]);
        dir_s1_q[c] <= dir_c[c];
      end
      tm_q[0] <= in_ch.ray_time;
    end
  end

  // ---------------- S2: cross products and edge squares ----------------
  logic signed [47:0] pvp_q [6], qvp_q [6];
  logic [62:0]        sq1_q [3], sq2_q [3];
  logic signed [31:0] e1_s2_q [3], e2_s2_q [3], tv_s2_q [3], dir_s2_q [3];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pvp_q[0] <= fmul(dir_s1_q[1], e2_s1_q[2]);
      pvp_q[1] <= fmul(dir_s1_q[2], e2_s1_q[1]);
      pvp_q[2] <= fmul(dir_s1_q[2], e2_s1_q[0]);
      pvp_q[3] <= fmul(dir_s1_q[0], e2_s1_q[2]);
      pvp_q[4] <= fmul(dir_s1_q[0], e2_s1_q[1]);
      pvp_q[5] <= fmul(dir_s1_q[1], e2_s1_q[0]);
      qvp_q[0] <= fmul(tv_s1_q[1], e1_s1_q[2]);
      qvp_q[1] <= fmul(tv_s1_q[2], e1_s1_q[1]);
      qvp_q[2] <= fmul(tv_s1_q[2], e1_s1_q[0]);
      qvp_q[3] <= fmul(tv_s1_q[0], e1_s1_q[2]);
      qvp_q[4] <= fmul(tv_s1_q[0], e1_s1_q[1]);
      qvp_q[5] <= fmul(tv_s1_q[1], e1_s1_q[0]);
      for (int c = 0; c < 3; c++) begin
        sq1_q[c]    <= square(e1_s1_q[c]);
        sq2_q[c]    <= square(e2_s1_q[c]);
        e1_s2_q[c]  <= e1_s1_q[c];
        e2_s2_q[c]  <= e2_s1_q[c];
        tv_s2_q[c]  <= tv_s1_q[c];
        dir_s2_q[c] <= dir_s1_q[c];
      end
      tm_q[1] <= tm_q[0];
    end
  end

  // ---------------- S3: pvec, qvec, squared lengths ----------------
  logic signed [31:0] pv_q [3], qv_q [3];
  logic [63:0]        s1_q, s2_q;
  logic signed [31:0] e1_s3_q [3], e2_s3_q [3], tv_s3_q [3], dir_s3_q [3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pv_q[0] <= cross_sat(pvp_q[0], pvp_q[1]);
      pv_q[1] <= cross_sat(pvp_q[2], pvp_q[3]);
      pv_q[2] <= cross_sat(pvp_q[4], pvp_q[5]);
      qv_q[0] <= cross_sat(qvp_q[0], qvp_q[1]);
      qv_q[1] <= cross_sat(qvp_q[2], qvp_q[3]);
      qv_q[2] <= cross_sat(qvp_q[4], qvp_q[5]);
      s1_q    <= {1'b0, sq1_q[0]} + {1'b0, sq1_q[1]} + {1'b0, sq1_q[2]};
      s2_q    <= {1'b0, sq2_q[0]} + {1'b0, sq2_q[1]} + {1'b0, sq2_q[2]};
      for (int c = 0; c < 3; c++) begin
        e1_s3_q[c]  <= e1_s2_q[c];
        e2_s3_q[c]  <= e2_s2_q[c];
        tv_s3_q[c]  <= tv_s2_q[c];
        dir_s3_q[c] <= dir_s2_q[c];
      end
      tm_q[2] <= tm_q[1];
    end
  end

  // ---------------- S4: dot product terms, longer edge ----------------
  logic signed [47:0] dp_q [3], up_q [3], vp_q [3], tp_q [3];
  logic [63:0]        smax_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int c = 0; c < 3; c++) begin
        dp_q[c] <= fmul(e1_s3_q[c], pv_q[c]);
        up_q[c] <= fmul(tv_s3_q[c], pv_q[c]);
        vp_q[c] <= fmul(dir_s3_q[c], qv_q[c]);
        tp_q[c] <= fmul(e2_s3_q[c], qv_q[c]);
      end
      smax_q  <= (s1_q > s2_q) ? s1_q : s2_q;
      tm_q[3] <= tm_q[2];
    end
  end

  // ---------------- S5: determinant and numerators ----------------
  logic signed [49:0] det_q, un_q, vn_q, tn_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      det_q   <= sum3(dp_q[0], dp_q[1], dp_q[2]);
      un_q    <= sum3(up_q[0], up_q[1], up_q[2]);
      vn_q    <= sum3(vp_q[0], vp_q[1], vp_q[2]);
      tn_q    <= sum3(tp_q[0], tp_q[1], tp_q[2]);
      tm_q[4] <= tm_q[3];
    end
  end

  // ---------------- S6: sign fold, range tests ----------------
  logic signed [49:0] dn, un_n, vn_n, tn_n, tabs;
  logic signed [50:0] uv_sum;
  logic [64:0]        t_sh, d_sh;
  rti_ctl_t           ctl_d;
  rti_ctl_t           ctl_q [CTL_N];
  logic [47:0]        dabs_s6_q, tabs_s6_q, un_s6_q, vn_s6_q;

  always_comb begin
    dn     = det_q[49] ? -det_q : det_q;
    un_n   = det_q[49] ? -un_q  : un_q;
    vn_n   = det_q[49] ? -vn_q  : vn_q;
    tn_n   = det_q[49] ? -tn_q  : tn_q;
    tabs   = tn_n[49] ? -tn_n : tn_n;
    uv_sum = 51'(un_n) + 51'(vn_n);
    t_sh   = {15'd0, tabs};
    d_sh   = {dn, 15'd0};
    ctl_d.miss     = (det_q == '0) || un_n[49] || (un_n > dn) || vn_n[49]
                  || (uv_sum > 51'(dn));
    ctl_d.tneg     = tn_n[49];
    ctl_d.tovf     = t_sh >= d_sh;
    ctl_d.dabs_big = |dn[49:30];
    ctl_d.dabs_lo  = dn[29:0];
    ctl_d.time_tag = tm_q[4];
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      ctl_q[0]  <= ctl_d;
      dabs_s6_q <= dn[47:0];
      tabs_s6_q <= tabs[47:0];
      un_s6_q   <= un_n[47:0];
      vn_s6_q   <= vn_n[47:0];
    end
    for (int k = 1; k < CTL_N; k++) begin
      if (en[6+k]) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // ---------------- S7..S37: quotients ----------------
  logic [30:0] tq;
  logic [16:0] uq, vq;

  rti_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[6+DIV_N:7]),
    .d_i    (dabs_s6_q),
    .tabs_i (tabs_s6_q),
    .un_i   (un_s6_q),
    .vn_i   (vn_s6_q),
    .tq_o   (tq),
    .uq_o   (uq),
    .vq_o   (vq)
  );

  // S38..S40: hold quotients until the tolerance is ready
  logic [30:0] tq_q [3];
  logic [16:0] uq_q [3], vq_q [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (en[38+k]) begin
        tq_q[k] <= (k == 0) ? tq : tq_q[(k == 0) ? 0 : k-1];
        uq_q[k] <= (k == 0) ? uq : uq_q[(k == 0) ? 0 : k-1];
        vq_q[k] <= (k == 0) ? vq : vq_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- S5..S40: tolerance ----------------
  logic [29:0] eps;

  rti_tol u_tol (
    .clk_i   (clk_i),
    .en_i    (en[4+TOL_N:5]),
    .x_i     (smax_q),
    .scale_i (eps_scale_q),
    .eps_o   (eps)
  );

  // ---------------- S41: verdict and output register ----------------
  rti_ctl_t    cf;
  logic [30:0] mag;
  logic        mag_nz, hit_d;
  logic        hit_q;
  logic [31:0] dist_q, time_q;
  logic [16:0] b1_q, b2_q, b3_q;

  always_comb begin
    cf     = ctl_q[CTL_N-1];
    mag    = cf.tovf ? T_MAX : tq_q[2];
    mag_nz = cf.tovf || (tq_q[2] != '0);
    hit_d  = !cf.miss
          && !(!cf.dabs_big && cf.dabs_lo < eps)
          && !(cf.tneg && mag_nz)
          && !(mag < {1'b0, eps});
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG]) begin
      hit_q  <= hit_d;
      dist_q <= hit_d ? {1'b0, mag} : '0;
      b1_q   <= hit_d ? (Q_ONE - uq_q[2] - vq_q[2]) : '0;
      b2_q   <= hit_d ? uq_q[2] : '0;
      b3_q   <= hit_d ? vq_q[2] : '0;
      time_q <= hit_d ? cf.time_tag : '0;
    end
  end

  assign out_ch.valid       = v_q[NSTG];
  assign out_ch.hit         = hit_q;
  assign out_ch.distance    = dist_q;
  assign out_ch.bary_first  = b1_q;
  assign out_ch.bary_second = b2_q;
  assign out_ch.bary_third  = b3_q;
  assign out_ch.hit_time    = time_q;

endmodule

`default_nettype wire

[rtl/rti_tol.sv]
`default_nettype none

// Tolerance: eps = floor(isqrt(x) * scale / 655360).
// 32 sqrt stages (one root bit each), one multiply stage, three /10 stages.
module rti_tol (
  input  logic                       clk_i,
  input  logic [rti_pkg::TOL_N-1:0]  en_i,
  input  logic [63:0]                x_i,
  input  logic [16:0]                scale_i,
  output logic [29:0]                eps_o
);
  import rti_pkg::*;

  logic [33:0] rem_q  [32];
  logic [31:0] root_q [32];
  logic [63:0] x_q    [32];

  // restoring square root, two radicand bits per stage
  for (genvar j = 0; j < 32; j++) begin : g_sq
    localparam int I = 31 - j;
    logic [33:0] rem_p;
    logic [31:0] root_p;
    logic [63:0] x_p;
    logic [35:0] r2, tt, df;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x_i;
    end else begin : g_next
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign x_p    = x_q[j-1];
    end

    assign r2 = {rem_p, x_p[2*I+1 -: 2]};
    assign tt = {2'b00, root_p, 2'b01};
    assign df = r2 - tt;

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        x_q[j] <= x_p;
        if (r2 >= tt) begin
          rem_q[j]  <= df[33:0];
          root_q[j] <= {root_p[30:0], 1'b1};
        end else begin
          rem_q[j]  <= r2[33:0];
          root_q[j] <= {root_p[30:0], 1'b0};
        end
      end
    end
  end

  // length times scale, drop the Q16 fraction
  logic [48:0] prod;
  logic [32:0] xs_q;

  assign prod = {17'd0, root_q[31]} * {32'd0, scale_i};

  always_ff @(posedge clk_i) begin
    if (en_i[32]) begin
      xs_q <= prod[48:16];
    end
  end

  // divide by ten, three hex digit steps per stage
  logic [35:0] dx_q [3];
  logic [35:0] dq_q [3];
  logic [3:0]  dr_q [3];

  for (genvar s = 0; s < 3; s++) begin : g_d10
    logic [35:0] x_p, q_p, q_d;
    logic [3:0]  r_p, r_d;
    logic [7:0]  st;

    if (s == 0) begin : g_first
      assign x_p = {3'd0, xs_q};
      assign q_p = '0;
      assign r_p = '0;
    end else begin : g_next
      assign x_p = dx_q[s-1];
      assign q_p = dq_q[s-1];
      assign r_p = dr_q[s-1];
    end

    always_comb begin
      q_d = q_p;
      r_d = r_p;
      st  = '0;
      for (int k = 0; k < 3; k++) begin
        st  = div10_step(r_d, x_p[4*(8-3*s-k) +: 4]);
        q_d = {q_d[31:0], st[7:4]};
        r_d = st[3:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[33+s]) begin
        dx_q[s] <= x_p;
        dq_q[s] <= q_d;
        dr_q[s] <= r_d;
      end
    end
  end

  assign eps_o = dq_q[2][29:0];

endmodule

`default_nettype wire

[rtl/rti_div.sv]
`default_nettype none

// Restoring dividers, one quotient bit per stage:
//   t = floor(tabs * 2^16 / d) for 31 bits, u and v = floor(n * 2^16 / d) for 17 bits.
module rti_div (
  input  logic                       clk_i,
  input  logic [rti_pkg::DIV_N-1:0]  en_i,
  input  logic [47:0]                d_i,
  input  logic [47:0]                tabs_i,
  input  logic [47:0]                un_i,
  input  logic [47:0]                vn_i,
  output logic [30:0]                tq_o,
  output logic [16:0]                uq_o,
  output logic [16:0]                vq_o
);
  import rti_pkg::*;

  logic [47:0] d_q  [DIV_N];
  logic [47:0] ta_q [DIV_N];
  logic [47:0] rt_q [DIV_N];
  logic [47:0] ru_q [DIV_N];
  logic [47:0] rv_q [DIV_N];
  logic [30:0] qt_q [DIV_N];
  logic [16:0] qu_q [DIV_N];
  logic [16:0] qv_q [DIV_N];
  logic        ub_q [DIV_N];
  logic        vb_q [DIV_N];

  for (genvar j = 0; j < DIV_N; j++) begin : g_st
    localparam int K = DIV_N - 1 - j;
    logic [47:0] d_p, ta_p, rt_p, ru_p, rv_p;
    logic [30:0] qt_p;
    logic [16:0] qu_p, qv_p;
    logic        ub_p, vb_p, nbt, nbu, nbv;
    logic [48:0] tt, tu, tv, dd;

    if (j == 0) begin : g_first
      assign d_p  = d_i;
      assign ta_p = tabs_i;
      assign rt_p = tabs_i >> 15;
      assign ru_p = un_i >> 1;
      assign rv_p = vn_i >> 1;
      assign qt_p = '0;
      assign qu_p = '0;
      assign qv_p = '0;
      assign ub_p = un_i[0];
      assign vb_p = vn_i[0];
    end else begin : g_next
      assign d_p  = d_q[j-1];
      assign ta_p = ta_q[j-1];
      assign rt_p = rt_q[j-1];
      assign ru_p = ru_q[j-1];
      assign rv_p = rv_q[j-1];
      assign qt_p = qt_q[j-1];
      assign qu_p = qu_q[j-1];
      assign qv_p = qv_q[j-1];
      assign ub_p = ub_q[j-1];
      assign vb_p = vb_q[j-1];
    end

    // dividend bit brought down at this quotient position
    if (K >= 16) begin : g_tb
      assign nbt = ta_p[K-16];
    end else begin : g_tz
      assign nbt = 1'b0;
    end
    if (K == 16) begin : g_ub
      assign nbu = ub_p;
      assign nbv = vb_p;
    end else begin : g_uz
      assign nbu = 1'b0;
      assign nbv = 1'b0;
    end

    assign dd = {1'b0, d_p};
    assign tt = {rt_p, nbt};
    assign tu = {ru_p, nbu};
    assign tv = {rv_p, nbv};

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        d_q[j]  <= d_p;
        ta_q[j] <= ta_p;
        ub_q[j] <= ub_p;
        vb_q[j] <= vb_p;
        if (tt >= dd) begin
          rt_q[j] <= 48'(tt - dd);
          qt_q[j] <= {qt_p[29:0], 1'b1};
        end else begin
          rt_q[j] <= tt[47:0];
          qt_q[j] <= {qt_p[29:0], 1'b0};
        end
        if (K > 16) begin
          ru_q[j] <= ru_p;
          rv_q[j] <= rv_p;
          qu_q[j] <= qu_p;
          qv_q[j] <= qv_p;
        end else begin
          if (tu >= dd) begin
            ru_q[j] <= 48'(tu - dd);
            qu_q[j] <= {qu_p[15:0], 1'b1};
          end else begin
            ru_q[j] <= tu[47:0];
            qu_q[j] <= {qu_p[15:0], 1'b0};
          end
          if (tv >= dd) begin
            rv_q[j] <= 48'(tv - dd);
            qv_q[j] <= {qv_p[15:0], 1'b1};
          end else begin
            rv_q[j] <= tv[47:0];
            qv_q[j] <= {qv_p[15:0], 1'b0};
          end
        end
      end
    end
  end

  assign tq_o = qt_q[DIV_N-1];
  assign uq_o = qu_q[DIV_N-1];
  assign vq_o = qv_q[DIV_N-1];

endmodule

`default_nettype wire
